// ----- rtl/tscrv_pkg.sv -----
// shared types, constants and helper functions for the tagged slot cache
// depends on nothing; imported by every module of the block
`default_nettype none

package tscrv_pkg;

    // cache geometry
    localparam int SLOT_COUNT = 16;
    localparam int TAG_WIDTH  = 16;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    // request mode codes
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_ALLOC  = 2'd1;
    localparam logic [1:0] MODE_DEACT  = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_ALLOC,
        ST_FINISH
    } ctrl_state_t;

    // outcome of a request, recorded during the scan
    typedef enum logic [1:0] {
        RES_NONE,
        RES_HIT,
        RES_ALLOC,
        RES_FULL
    } res_kind_t;

    // controller to datapath
    typedef struct packed {
        logic      load_req;
        logic      advance;
        logic      start_alloc;
        logic      kind_we;
        res_kind_t kind;
        logic      commit;
    } tscrv_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       match;
        logic       free;
        logic       last;
        logic       out_free;
    } tscrv_stat_t;

    // sign-extend a 16-bit coordinate, keep TAG_WIDTH bits
    function automatic logic [TAG_WIDTH-1:0] make_tag(input logic signed [15:0] v);
        logic signed [31:0] ext;
        ext = 32'(v);
        return ext[TAG_WIDTH-1:0];
    endfunction

    // low 16 bits of a stored tag, zero-extended when the tag is narrower
    function automatic logic [15:0] tag_low16(input logic [TAG_WIDTH-1:0] t);
        logic [31:0] z;
        z = 32'(t);
        return z[15:0];
    endfunction

    // slot index as the 4-bit result code
    function automatic logic [3:0] slot_code(input logic [IDX_W-1:0] i);
        logic [IDX_W+3:0] z;
        z = (IDX_W + 4)'(i);
        return z[3:0];
    endfunction

    // next slot index with wraparound
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tscrv_ctrl.sv -----
// controller state machine: sequences lookup scan, victim scan and commit
// depends on tscrv_pkg; drives the datapath through tscrv_cmd_t
`default_nettype none

module tscrv_ctrl import tscrv_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic [1:0]  s_mode,
    output logic             s_ready,
    input  wire tscrv_stat_t stat,
    output tscrv_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_mode inside {MODE_LOOKUP, MODE_ALLOC}) begin
                        state_next = ST_LOOKUP;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_LOOKUP: begin
                if (stat.match) begin
                    state_next = ST_FINISH;
                end else if (stat.last) begin
                    state_next = (stat.mode == MODE_ALLOC) ? ST_ALLOC : ST_FINISH;
                end
            end
            ST_ALLOC: begin
                if (stat.free || stat.last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready         = 1'b0;
        cmd.load_req    = 1'b0;
        cmd.advance     = 1'b0;
        cmd.start_alloc = 1'b0;
        cmd.kind_we     = 1'b0;
        cmd.kind        = RES_NONE;
        cmd.commit      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            ST_LOOKUP: begin
                if (stat.match) begin
                    cmd.kind_we = 1'b1;
                    cmd.kind    = RES_HIT;
                end else if (stat.last) begin
                    cmd.start_alloc = (stat.mode == MODE_ALLOC);
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            ST_ALLOC: begin
                if (stat.free) begin
                    cmd.kind_we = 1'b1;
                    cmd.kind    = RES_ALLOC;
                end else if (stat.last) begin
                    cmd.kind_we = 1'b1;
                    cmd.kind    = RES_FULL;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            ST_FINISH: begin
                cmd.commit = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/tscrv_dpath.sv -----
// datapath: slot tags and flags, scan index, victim pointer, result register
// depends on tscrv_pkg; controlled by tscrv_ctrl through tscrv_cmd_t
`default_nettype none

module tscrv_dpath import tscrv_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [1:0]         s_mode,
    input  wire logic signed [15:0] s_tag_x,
    input  wire logic signed [15:0] s_tag_y,
    input  wire logic [3:0]         s_target_slot,
    input  wire tscrv_cmd_t         cmd,
    output tscrv_stat_t             stat,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_hit,
    output logic [3:0]              m_slot_out,
    output logic                    m_allocated,
    output logic                    m_evicted,
    output logic signed [15:0]      m_evict_x,
    output logic signed [15:0]      m_evict_y,
    output logic                    m_full_res
);

    // slot storage
    logic [TAG_WIDTH-1:0]  tag_x_reg [SLOT_COUNT];
    logic [TAG_WIDTH-1:0]  tag_y_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] loaded_reg;
    logic [SLOT_COUNT-1:0] active_reg;
    logic [IDX_W-1:0]      ptr_reg;

    // latched request
    logic [1:0]           req_mode_reg;
    logic [TAG_WIDTH-1:0] req_x_reg;
    logic [TAG_WIDTH-1:0] req_y_reg;
    logic [3:0]           req_target_reg;

    // scan state
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] cnt_reg;
    res_kind_t        kind_reg;

    // result register
    logic              m_valid_reg;
    logic              hit_reg;
    logic [3:0]        slot_reg;
    logic              alloc_reg;
    logic              evict_reg;
    logic signed [15:0] evict_x_reg;
    logic signed [15:0] evict_y_reg;
    logic              full_reg;

    logic [TAG_WIDTH-1:0] cur_x;
    logic [TAG_WIDTH-1:0] cur_y;
    logic [31:0]          target_wide;
    logic [IDX_W-1:0]     target_idx;
    logic                 target_ok;

    // current slot under the scan
    assign cur_x       = tag_x_reg[idx_reg];
    assign cur_y       = tag_y_reg[idx_reg];
    assign target_wide = 32'(req_target_reg);
    assign target_idx  = target_wide[IDX_W-1:0];
    assign target_ok   = (target_wide < SLOT_COUNT);

    // status to the controller
    always_comb begin
        stat.mode     = req_mode_reg;
        stat.match    = loaded_reg[idx_reg] && (cur_x == req_x_reg) && (cur_y == req_y_reg);
        stat.free     = !active_reg[idx_reg];
        stat.last     = (cnt_reg == LAST_IDX);
        stat.out_free = !m_valid_reg || m_ready;
    end

    // request capture and scan index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= RES_NONE;
        end else begin
            if (cmd.load_req) begin
                kind_reg <= RES_NONE;
            end else if (cmd.kind_we) begin
                kind_reg <= cmd.kind;
            end
        end
        if (cmd.load_req) begin
            req_mode_reg   <= s_mode;
            req_x_reg      <= make_tag(s_tag_x);
            req_y_reg      <= make_tag(s_tag_y);
            req_target_reg <= s_target_slot;
            idx_reg        <= '0;
            cnt_reg        <= '0;
        end else if (cmd.start_alloc) begin
            idx_reg <= ptr_reg;
            cnt_reg <= '0;
        end else if (cmd.advance) begin
            idx_reg <= next_idx(idx_reg);
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // slot flags and victim pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= '0;
            active_reg <= '0;
            ptr_reg    <= '0;
        end else if (cmd.commit) begin
            if (req_mode_reg == MODE_DEACT) begin
                if (target_ok) begin
                    active_reg[target_idx] <= 1'b0;
                end
            end else begin
                case (kind_reg)
                    RES_HIT: begin
                        active_reg[idx_reg] <= 1'b1;
                    end
                    RES_ALLOC: begin
                        active_reg[idx_reg] <= 1'b1;
                        loaded_reg[idx_reg] <= 1'b1;
                        ptr_reg             <= idx_reg;
                    end
                    default: begin
                        ptr_reg <= ptr_reg;
                    end
                endcase
            end
        end
    end

    // tag write on allocation
    always_ff @(posedge aclk) begin
        if (cmd.commit && (req_mode_reg != MODE_DEACT) && (kind_reg == RES_ALLOC)) begin
            tag_x_reg[idx_reg] <= req_x_reg;
            tag_y_reg[idx_reg] <= req_y_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.commit) begin
            hit_reg     <= 1'b0;
            slot_reg    <= '0;
            alloc_reg   <= 1'b0;
            evict_reg   <= 1'b0;
            evict_x_reg <= '0;
            evict_y_reg <= '0;
            full_reg    <= 1'b0;
            if (req_mode_reg != MODE_DEACT) begin
                case (kind_reg)
                    RES_HIT: begin
                        hit_reg  <= 1'b1;
                        slot_reg <= slot_code(idx_reg);
                    end
                    RES_ALLOC: begin
                        slot_reg  <= slot_code(idx_reg);
                        alloc_reg <= 1'b1;
                        if (loaded_reg[idx_reg]) begin
                            evict_reg   <= 1'b1;
                            evict_x_reg <= tag_low16(cur_x);
                            evict_y_reg <= tag_low16(cur_y);
                        end
                    end
                    RES_FULL: begin
                        full_reg <= 1'b1;
                    end
                    default: begin
                        hit_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = hit_reg;
    assign m_slot_out  = slot_reg;
    assign m_allocated = alloc_reg;
    assign m_evicted   = evict_reg;
    assign m_evict_x   = evict_x_reg;
    assign m_evict_y   = evict_y_reg;
    assign m_full_res  = full_reg;

endmodule

`default_nettype wire

// ----- rtl/tagged_slot_cache_rotating_victim_core.sv -----
// top level of the tagged slot cache with rotating victim search
// depends on tscrv_pkg, tscrv_ctrl and tscrv_dpath
//
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  mode, tag_x, tag_y, target_slot
//  m_        out        m_valid / m_ready  hit, slot_out, allocated, evicted,
//                                          evict_x, evict_y, full_res
//
// one request at a time: accept, then a lookup scan of one slot per
// cycle (stops at the first hit), then for a missed allocate request a victim
// scan of one slot per cycle from the pointer, then commit; a single compare
// unit steps over the slots.
// deactivate and unused mode skip both scans and go straight to commit.
// reset clears loaded and active flags and the pointer at once.
// commit waits while a previous result sits unaccepted in the output register.
`default_nettype none

module tagged_slot_cache_rotating_victim_core import tscrv_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_mode,
    input  wire logic signed [15:0] s_tag_x,
    input  wire logic signed [15:0] s_tag_y,
    input  wire logic [3:0]         s_target_slot,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_hit,
    output logic [3:0]              m_slot_out,
    output logic                    m_allocated,
    output logic                    m_evicted,
    output logic signed [15:0]      m_evict_x,
    output logic signed [15:0]      m_evict_y,
    output logic                    m_full_res
);

    tscrv_cmd_t  cmd;
    tscrv_stat_t stat;

    // sequencer
    tscrv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // slot storage and result register
    tscrv_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_mode        (s_mode),
        .s_tag_x       (s_tag_x),
        .s_tag_y       (s_tag_y),
        .s_target_slot (s_target_slot),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_slot_out    (m_slot_out),
        .m_allocated   (m_allocated),
        .m_evicted     (m_evicted),
        .m_evict_x     (m_evict_x),
        .m_evict_y     (m_evict_y),
        .m_full_res    (m_full_res)
    );

    // commit only into a free output register
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready))
        else $error("commit while result register busy");

    // a commit always presents a result next cycle
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("commit did not produce a result");

    // full excludes every other outcome
    a_full_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_full_res) |-> (!m_hit && !m_allocated && !m_evicted))
        else $error("full reported together with another outcome");

    // eviction only with allocation, never with a hit
    a_evict_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((!m_evicted || m_allocated) && !(m_hit && m_allocated)))
        else $error("inconsistent hit and allocation flags");

endmodule

`default_nettype wire

// ----- dv/tagged_slot_cache_rotating_victim_core_test.sv -----
// self-checking testbench for the tagged slot cache core: directed and random requests
// depends on tscrv_pkg and tagged_slot_cache_rotating_victim_core; results checked in order
module tagged_slot_cache_rotating_victim_core_test;
    import tscrv_pkg::*;

    // request code the package leaves unnamed
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // longest request: lookup scan, victim scan and commit
    localparam int SCAN_CYCLES = 2 * SLOT_COUNT + 2;
    localparam int POOL_SIZE = 24;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic        allocated;
        logic        evicted;
        logic [15:0] evict_x;
        logic [15:0] evict_y;
        logic        full;
    } cache_result_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_LIGHT,
        READY_HEAVY,
        READY_PERIODIC
    } ready_style_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_mode;
    logic [15:0]       s_tag_x;
    logic [15:0]       s_tag_y;
    logic [3:0]        s_target_slot;
    logic              m_valid;
    logic              m_ready;
    logic              m_hit;
    logic [3:0]        m_slot_out;
    logic              m_allocated;
    logic              m_evicted;
    logic [15:0]       m_evict_x;
    logic [15:0]       m_evict_y;
    logic              m_full_res;

    // shadow copy of the cache contents
    logic [TAG_WIDTH-1:0] shadow_x [SLOT_COUNT];
    logic [TAG_WIDTH-1:0] shadow_y [SLOT_COUNT];
    logic                 shadow_loaded [SLOT_COUNT];
    logic                 shadow_active [SLOT_COUNT];
    logic [IDX_W-1:0]     shadow_ptr;

    cache_result_t pending_results [$];
    int            fail_count;
    int            requests_sent;
    int            burst_left;
    logic [15:0]   pool_x [POOL_SIZE];
    logic [15:0]   pool_y [POOL_SIZE];

    ready_style_t  ready_style;
    int            ready_left;
    int            ready_tick;

    tagged_slot_cache_rotating_victim_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_tag_x       (s_tag_x),
        .s_tag_y       (s_tag_y),
        .s_target_slot (s_target_slot),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_slot_out    (m_slot_out),
        .m_allocated   (m_allocated),
        .m_evicted     (m_evicted),
        .m_evict_x     (m_evict_x),
        .m_evict_y     (m_evict_y),
        .m_full_res    (m_full_res)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // widen a 16-bit coordinate to the stored tag width
    function automatic logic [TAG_WIDTH-1:0] widen_coord(input logic [15:0] v);
        logic [31:0] ext;
        ext = {{16{v[15]}}, v};
        return ext[TAG_WIDTH-1:0];
    endfunction

    // expected outcome of one request, updating the shadow cache
    function automatic cache_result_t cache_access(input logic [1:0] mode,
                                                   input logic [15:0] x,
                                                   input logic [15:0] y,
                                                   input logic [3:0] target);
        cache_result_t        r;
        logic [TAG_WIDTH-1:0] tx;
        logic [TAG_WIDTH-1:0] ty;
        logic [31:0]          wide;
        int                   idx;
        r = '0;
        tx = widen_coord(x);
        ty = widen_coord(y);
        if (mode == MODE_DEACT) begin
            if (int'(target) < SLOT_COUNT) shadow_active[target] = 1'b0;
            return r;
        end
        if (mode == MODE_UNUSED) return r;
        // lookup: first loaded slot with matching tag
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (shadow_loaded[i] && shadow_x[i] == tx && shadow_y[i] == ty) begin
                shadow_active[i] = 1'b1;
                r.hit = 1'b1;
                r.slot = 4'(i);
                return r;
            end
        end
        if (mode == MODE_LOOKUP) return r;
        // allocate: first inactive slot from the victim pointer
        for (int k = 0; k < SLOT_COUNT; k++) begin
            idx = (int'(shadow_ptr) + k) % SLOT_COUNT;
            if (!shadow_active[idx]) begin
                shadow_ptr = IDX_W'(idx);
                if (shadow_loaded[idx]) begin
                    r.evicted = 1'b1;
                    wide = 32'(shadow_x[idx]);
                    r.evict_x = wide[15:0];
                    wide = 32'(shadow_y[idx]);
                    r.evict_y = wide[15:0];
                end
                shadow_x[idx] = tx;
                shadow_y[idx] = ty;
                shadow_loaded[idx] = 1'b1;
                shadow_active[idx] = 1'b1;
                r.slot = 4'(idx);
                r.allocated = 1'b1;
                return r;
            end
        end
        r.full = 1'b1;
        return r;
    endfunction

    // send one request in bursts with random gaps, predict on acceptance
    task automatic send_request(input logic [1:0] mode, input logic [15:0] x,
                                input logic [15:0] y, input logic [3:0] target);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid = 1'b1;
        s_mode = mode;
        s_tag_x = x;
        s_tag_y = y;
        s_target_slot = target;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(cache_access(mode, x, y, target));
        requests_sent++;
    endtask

    // empty cache: zero tags must not hit, unused mode and idle deactivate
    task automatic test_empty_cache();
        send_request(MODE_LOOKUP, 16'h0000, 16'h0000, 4'd0);
        send_request(MODE_UNUSED, 16'hffff, 16'h8000, 4'd15);
        send_request(MODE_DEACT, 16'h7fff, 16'h0001, 4'd15);
        send_request(MODE_LOOKUP, 16'h8000, 16'h7fff, 4'd5);
    endtask

    // allocate extreme tags, then hit on each of them
    task automatic test_allocate_extremes();
        logic [15:0] ex [5];
        logic [15:0] ey [5];
        ex = '{16'h8000, 16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        ey = '{16'h8000, 16'h7fff, 16'h7fff, 16'h0000, 16'hffff};
        for (int i = 0; i < 5; i++) send_request(MODE_ALLOC, ex[i], ey[i], 4'd0);
        for (int i = 0; i < 5; i++) send_request(MODE_LOOKUP, ex[i], ey[i], 4'd0);
        send_request(MODE_ALLOC, 16'h0000, 16'h0000, 4'd0);
    endtask

    // free loaded slots and reallocate so a tag gets evicted
    task automatic test_deactivate_evict();
        send_request(MODE_DEACT, 16'h0000, 16'h0000, 4'd0);
        send_request(MODE_DEACT, 16'h0000, 16'h0000, 4'd4);
        send_request(MODE_ALLOC, 16'h1234, 16'hedcb, 4'd0);
        send_request(MODE_LOOKUP, 16'hffff, 16'hffff, 4'd0);
        send_request(MODE_ALLOC, 16'h8001, 16'h7ffe, 4'd0);
    endtask

    // fill with fresh tags until full, then free a few slots and refill
    task automatic test_full_cache();
        int n;
        n = $urandom_range(17, 22);
        for (int i = 0; i < n; i++)
            send_request(MODE_ALLOC, 16'($urandom), 16'($urandom), 4'($urandom));
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            send_request(MODE_DEACT, 16'($urandom), 16'($urandom), 4'($urandom_range(0, 15)));
        n = $urandom_range(2, 6);
        for (int i = 0; i < n; i++)
            send_request(MODE_ALLOC, 16'($urandom), 16'($urandom), 4'($urandom));
    endtask

    // small tag pool with frequent deactivation: hits, near misses, evictions
    task automatic test_churn(input int count);
        int          pick;
        int          roll;
        logic [15:0] flip;
        for (int i = 0; i < POOL_SIZE; i++) begin
            case ($urandom_range(0, 7))
                0: pool_x[i] = 16'h8000;
                1: pool_x[i] = 16'h7fff;
                default: pool_x[i] = 16'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0: pool_y[i] = 16'hffff;
                1: pool_y[i] = 16'h0000;
                default: pool_y[i] = 16'($urandom);
            endcase
        end
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, POOL_SIZE - 1);
            roll = $urandom_range(0, 99);
            flip = 16'h0001 << $urandom_range(0, 15);
            if (roll < 45)
                send_request(MODE_ALLOC, pool_x[pick], pool_y[pick], 4'($urandom));
            else if (roll < 65)
                send_request(MODE_LOOKUP, pool_x[pick], pool_y[pick], 4'($urandom));
            else if (roll < 70)
                send_request(roll[0] ? MODE_LOOKUP : MODE_ALLOC,
                             roll[1] ? pool_x[pick] ^ flip : pool_x[pick],
                             roll[1] ? pool_y[pick] : pool_y[pick] ^ flip, 4'($urandom));
            else if (roll < 92)
                send_request(MODE_DEACT, 16'($urandom), 16'($urandom),
                             4'($urandom_range(0, 15)));
            else if (roll < 96)
                send_request(MODE_UNUSED, pool_x[pick], pool_y[pick], 4'($urandom));
            else
                send_request(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                             4'($urandom));
        end
    endtask

    // unstructured requests over every field
    task automatic test_noise(input int count);
        for (int i = 0; i < count; i++)
            send_request(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                         4'($urandom_range(0, 15)));
    endtask

    // receiver stall pattern, switching between random styles
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_style = ready_style_t'($urandom_range(0, 3));
            ready_left = $urandom_range(20, 200);
        end
        ready_left--;
        ready_tick++;
        case (ready_style)
            READY_ALWAYS:   m_ready = 1'b1;
            READY_LIGHT:    m_ready = ($urandom_range(0, 99) >= 30);
            READY_HEAVY:    m_ready = ($urandom_range(0, 99) >= 80);
            default:        m_ready = (ready_tick % 4 == 0);
        endcase
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        cache_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request pending, expected none, actual %h",
                         $time, {m_hit, m_slot_out, m_allocated, m_evicted,
                                 m_evict_x, m_evict_y, m_full_res});
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", 16'(want.hit), 16'(m_hit));
                check_field("slot_out", 16'(want.slot), 16'(m_slot_out));
                check_field("allocated", 16'(want.allocated), 16'(m_allocated));
                check_field("evicted", 16'(want.evicted), 16'(m_evicted));
                check_field("evict_x", want.evict_x, m_evict_x);
                check_field("evict_y", want.evict_y, m_evict_y);
                check_field("full_res", 16'(want.full), 16'(m_full_res));
            end
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // main sequence
    initial begin
        int roll;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = MODE_LOOKUP;
        s_tag_x = '0;
        s_tag_y = '0;
        s_target_slot = '0;
        m_ready = 1'b0;
        fail_count = 0;
        requests_sent = 0;
        burst_left = 0;
        ready_style = READY_ALWAYS;
        ready_left = 0;
        ready_tick = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            shadow_x[i] = '0;
            shadow_y[i] = '0;
            shadow_loaded[i] = 1'b0;
            shadow_active[i] = 1'b0;
        end
        shadow_ptr = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_cache();
        test_allocate_extremes();
        test_deactivate_evict();
        test_full_cache();
        while (requests_sent < 1050) begin
            roll = $urandom_range(0, 99);
            if (roll < 20)
                test_full_cache();
            else if (roll < 85)
                test_churn($urandom_range(20, 60));
            else
                test_noise($urandom_range(5, 25));
        end

        // drain
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SCAN_CYCLES + 4) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
